FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dpsq_pkg.sv
// ----------------------------------------------------------------------------
// dpsq_pkg
// Types and codes of the dual policy service queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsq_pkg;

  // request operation codes; any code with bit 1 set serves the richest entry
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpOldest = 2'd1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StServed   = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    STake,
    SSkipRd,
    SSkipChk,
    SFinish
  } state_e;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] id;
    logic        waiting;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/dpsq_ram.sv
// ----------------------------------------------------------------------------
// dpsq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/dual_policy_service_queue_core.sv
// ----------------------------------------------------------------------------
// dual_policy_service_queue_core
// Arrival-ordered queue served either oldest-first or by largest value.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries operation_i and amount_i:
//   insert, serve oldest, or serve richest (any code with bit 1 set).
//   Response channel (out_valid_o/out_ready_i) returns status_o and
//   served_id_o, exactly one response per request, in order.
//   Insert, full and empty requests answer in the cycle after acceptance.
//   Serve oldest scans only the head slot; serve richest scans the span,
//   the number of slots from head to tail. Both then clear the served
//   entry's waiting flag and free the holes at the head. The scan is set by
//   the single RAM read port: it reads one slot per cycle and the compare
//   unit checks one entry per cycle. The block takes no request while a serve
//   is in work. A finished response sits in an output register; the next
//   request is taken as soon as that register is free or being drained.
//   A stalled receiver holds the response and, after a serve, holds the
//   sequencer.
//   Reset empties the queue and restarts arrival numbers at 1; entry storage
//   is not cleared, as only read data from slots inside the span is used.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_policy_service_queue_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] amount_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      served_id_o
);

  localparam int unsigned SW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [SW-1:0] LastSlot = SW'(DEPTH - 1);
  localparam logic [CW-1:0] SpanFull = CW'(DEPTH);

  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
    slot_next = (s == LastSlot) ? '0 : s + SW'(1);
  endfunction

  dpsq_pkg::state_e state_q, state_d;

  logic [SW-1:0] head_q, head_d;
  logic [SW-1:0] tail_q, tail_d;
  logic [CW-1:0] span_q, span_d;
  logic [31:0]   next_id_q, next_id_d;

  logic [SW-1:0] scan_ptr_q, scan_ptr_d;
  logic [CW-1:0] scan_left_q, scan_left_d;
  logic          rd_vld_q, rd_vld_d;
  logic [SW-1:0] rd_slot_q, rd_slot_d;
  logic          found_q, found_d;
  logic [SW-1:0] best_slot_q, best_slot_d;
  logic [31:0]   best_value_q, best_value_d;
  logic [31:0]   best_id_q, best_id_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] served_id_q, served_id_d;

  logic                         ram_we;
  logic [SW-1:0]                ram_waddr;
  dpsq_pkg::entry_t             ram_wentry;
  logic [SW-1:0]                ram_raddr;
  logic [dpsq_pkg::EntryW-1:0]  ram_rdata;
  dpsq_pkg::entry_t             rd_entry;

  logic out_free;
  logic in_fire;

  assign rd_entry = dpsq_pkg::entry_t'(ram_rdata);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == dpsq_pkg::SIdle) && out_free;
  assign in_fire = in_valid_i && in_ready_o;

  dpsq_ram #(
    .WIDTH (dpsq_pkg::EntryW),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    span_d       = span_q;
    next_id_d    = next_id_q;
    scan_ptr_d   = scan_ptr_q;
    scan_left_d  = scan_left_q;
    rd_vld_d     = 1'b0;
    rd_slot_d    = rd_slot_q;
    found_d      = found_q;
    best_slot_d  = best_slot_q;
    best_value_d = best_value_q;
    best_id_d    = best_id_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    served_id_d  = served_id_q;
    ram_we       = 1'b0;
    ram_waddr    = tail_q;
    ram_wentry   = '{value: amount_i, id: next_id_q, waiting: 1'b1};
    ram_raddr    = head_q;

    unique case (state_q)
      dpsq_pkg::SIdle: begin
        if (in_fire) begin
          if (operation_i == dpsq_pkg::OpInsert) begin
            out_valid_d = 1'b1;
            served_id_d = '0;
            if (span_q == SpanFull) begin
              status_d = dpsq_pkg::StFull;
            end else begin
              ram_we    = 1'b1;
              tail_d    = slot_next(tail_q);
              span_d    = span_q + CW'(1);
              next_id_d = next_id_q + 32'd1;
              status_d  = dpsq_pkg::StInserted;
            end
          end else if (span_q == '0) begin
            out_valid_d = 1'b1;
            status_d    = dpsq_pkg::StEmpty;
            served_id_d = '0;
          end else begin
            // the head is always waiting, so serve oldest is a one-slot scan
            scan_ptr_d  = head_q;
            scan_left_d = (operation_i == dpsq_pkg::OpOldest) ? CW'(1) : span_q;
            found_d     = 1'b0;
            state_d     = dpsq_pkg::SScan;
          end
        end
      end

      dpsq_pkg::SScan: begin
        if (scan_left_q != '0) begin
          ram_raddr   = scan_ptr_q;
          rd_slot_d   = scan_ptr_q;
          rd_vld_d    = 1'b1;
          scan_ptr_d  = slot_next(scan_ptr_q);
          scan_left_d = scan_left_q - CW'(1);
        end
        // strict compare keeps the earliest arrival on ties
        if (rd_vld_q && rd_entry.waiting &&
            (!found_q || (rd_entry.value > best_value_q))) begin
          found_d      = 1'b1;
          best_slot_d  = rd_slot_q;
          best_value_d = rd_entry.value;
          best_id_d    = rd_entry.id;
        end
        if ((scan_left_q == '0) && !rd_vld_q) begin
          state_d = dpsq_pkg::STake;
        end
      end

      dpsq_pkg::STake: begin
        ram_we      = 1'b1;
        ram_waddr   = best_slot_q;
        ram_wentry  = '{value: best_value_q, id: best_id_q, waiting: 1'b0};
        state_d     = dpsq_pkg::SSkipRd;
      end

      dpsq_pkg::SSkipRd: begin
        ram_raddr = head_q;
        state_d   = dpsq_pkg::SSkipChk;
      end

      dpsq_pkg::SSkipChk: begin
        // read data belongs to the current head; fetch the following slot ahead
        if ((span_q == '0) || rd_entry.waiting) begin
          state_d = dpsq_pkg::SFinish;
        end else begin
          head_d    = slot_next(head_q);
          span_d    = span_q - CW'(1);
          ram_raddr = slot_next(head_q);
        end
      end

      dpsq_pkg::SFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = dpsq_pkg::StServed;
          served_id_d = best_id_q;
          state_d     = dpsq_pkg::SIdle;
        end
      end

      default: begin
        state_d = dpsq_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpsq_pkg::SIdle;
      head_q      <= '0;
      tail_q      <= '0;
      span_q      <= '0;
      next_id_q   <= 32'd1;
      scan_left_q <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      span_q      <= span_d;
      next_id_q   <= next_id_d;
      scan_left_q <= scan_left_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_ptr_q   <= scan_ptr_d;
    rd_slot_q    <= rd_slot_d;
    best_slot_q  <= best_slot_d;
    best_value_q <= best_value_d;
    best_id_q    <= best_id_d;
    status_q     <= status_d;
    served_id_q  <= served_id_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign served_id_o = served_id_q;

endmodule

`default_nettype wire

FILE: rtl/dpsq_checker.sv
// ----------------------------------------------------------------------------
// dpsq_checker
// Port-level checks of the service queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dpsq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] served_id_o
);

  // a stalled response must hold
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(served_id_o), "response changed while stalled")

  // only a served response carries an arrival number
  `ASSERT_IMPLY(a_id_zero, clk_i, rst_ni, out_valid_o && (status_o != dpsq_pkg::StServed), served_id_o == 32'd0, "non-zero id on a response that serves nothing")

  // an accepted request either answers next cycle or keeps the block busy
  `ASSERT_NEXT(a_req_busy, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o || !in_ready_o, "request accepted without response or busy state")

  // while busy, no new response other than a serve appears
  `ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !out_valid_o && !in_ready_o && $past(!in_ready_o) && $past(!out_valid_o) && (status_o != dpsq_pkg::StServed), !out_valid_o || (status_o == dpsq_pkg::StServed), "non-serve response while busy")

endmodule

bind dual_policy_service_queue_core dpsq_checker u_dpsq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .served_id_o (served_id_o)
);

`default_nettype wire
